[src/mdet_pkg.sv]
package mdet_pkg;

  localparam int CHANNELS   = 8;
  localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_W       = 3;
  localparam int TS_W       = 32;
  localparam int AT_W       = 16;
  localparam int CNT_W      = 8;
  localparam int STEP_W     = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [CNT_W-1:0]  TICKS_RST = 8'd2;
  localparam logic [STEP_W-1:0] STEP_RST  = 8'd10;
  localparam logic [AT_W-1:0]   AT_MAX    = '1;

  typedef enum logic [1:0] {
    EDGE_NONE = 2'd0,
    EDGE_RISE = 2'd1,
    EDGE_FALL = 2'd2
  } edge_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TICKS = 4'd0,
    REG_TIME_STEP      = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic              level;
    logic [CNT_W-1:0]  cnt;
    logic [AT_W-1:0]   active;
    logic [TS_W-1:0]   stamp;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0]  ticks;
    logic [STEP_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            pin_level;
    logic [TS_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [CH_W-1:0] channel_out;
    logic            stable_level;
    edge_t           edge_res;
    logic [AT_W-1:0] active_time_ms;
    logic [TS_W-1:0] trigger_time_ms;
  } result_t;

endpackage

[src/mdet_in_if.sv]
interface mdet_in_if;
  import mdet_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] channel;
  logic            pin_level;
  logic [TS_W-1:0] now_ms;

  modport source (output valid, channel, pin_level, now_ms, input ready);
  modport sink   (input valid, channel, pin_level, now_ms, output ready);
endinterface

[src/mdet_out_if.sv]
interface mdet_out_if;
  import mdet_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] channel_out;
  logic            stable_level;
  logic [1:0]      edge_res;
  logic [AT_W-1:0] active_time_ms;
  logic [TS_W-1:0] trigger_time_ms;

  modport source (output valid, channel_out, stable_level, edge_res, active_time_ms,
                  trigger_time_ms, input ready);
  modport sink   (input valid, channel_out, stable_level, edge_res, active_time_ms,
                  trigger_time_ms, output ready);
endinterface

[src/mdet_cfg_if.sv]
interface mdet_cfg_if;
  import mdet_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

[src/mdet_update.sv]
module mdet_update (
  input  mdet_pkg::sample_t smp_i,
  input  mdet_pkg::entry_t  cur_i,
  input  mdet_pkg::cfg_t    cfg_i,
  output mdet_pkg::entry_t  nxt_o,
  output logic              wr_en_o,
  output mdet_pkg::result_t res_o
);
  import mdet_pkg::*;

  logic             present;
  logic             mismatch;
  logic             take;
  logic [CNT_W-1:0] cnt_inc;
  logic [AT_W:0]    sum;
  entry_t           base;
  edge_t            edge_v;

  always_comb begin
    present  = int'(smp_i.channel) < CHANNELS;
    mismatch = smp_i.pin_level != cur_i.level;
    cnt_inc  = cur_i.cnt + 1'b1;
    // a ticks setting of zero accepts on the first differing sample
    take     = mismatch && (cnt_inc >= cfg_i.ticks);

    base     = cur_i;
    base.cnt = (mismatch && !take) ? cnt_inc : '0;
    edge_v   = EDGE_NONE;
    if (take) begin
      base.level = smp_i.pin_level;
      if (smp_i.pin_level) begin
        edge_v      = EDGE_RISE;
        base.active = '0;
        base.stamp  = smp_i.now_ms;
      end else begin
        edge_v = EDGE_FALL;
      end
    end

    sum   = {1'b0, base.active} + {{(AT_W + 1 - STEP_W){1'b0}}, cfg_i.step};
    nxt_o = base;
    if (base.level) begin
      nxt_o.active = sum[AT_W] ? AT_MAX : sum[AT_W-1:0];
    end

    wr_en_o = present;

    res_o.channel_out = smp_i.channel;
    if (present) begin
      res_o.stable_level    = nxt_o.level;
      res_o.edge_res        = edge_v;
      res_o.active_time_ms  = nxt_o.active;
      res_o.trigger_time_ms = nxt_o.stamp;
    end else begin
      res_o.stable_level    = 1'b0;
      res_o.edge_res        = EDGE_NONE;
      res_o.active_time_ms  = '0;
      res_o.trigger_time_ms = '0;
    end
  end

endmodule

[src/multichannel_debounce_edge_timer.sv]
// channel  direction  fields                                             transfer
// in_if    sink       channel, pin_level, now_ms                         valid & ready
// out_if   source     channel_out, stable_level, edge_res,               valid & ready
//                     active_time_ms, trigger_time_ms
// cfg_if   sink       idx (0 debounce_ticks, 1 time_step_ms), data       valid & ready
//
// one sample per cycle sustained unless the output stalls; the result is registered
// per-channel state sits in one memory read at accept and written back on advance,
// a write to the entry being read in the same cycle is forwarded into the read register
// reset clears the per-entry valid bits, invalid entries read as zero
// a stalled output holds the result register and the update stage, input waits only
// when both are full
module multichannel_debounce_edge_timer (
  input  logic             clk,
  input  logic             rst_n,
  mdet_in_if.sink          in_if,
  mdet_out_if.source       out_if,
  mdet_cfg_if.sink         cfg_if
);
  import mdet_pkg::*;

  cfg_t              cfg_r;
  cfg_t              cfg_nxt;

  entry_t            mem_r [CHANNELS];
  logic [CHANNELS-1:0] ent_vld_r;

  logic              s1_vld_r;
  sample_t           s1_smp_r;
  entry_t            rd_r;
  logic              rd_vld_r;

  logic              out_vld_r;
  result_t           out_res_r;

  logic              in_acc;
  logic              s1_adv;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  wr_idx;
  logic              wr_go;
  logic              fwd;
  entry_t            cur;
  entry_t            upd_nxt;
  logic              upd_wr;
  result_t           upd_res;

  // configuration
  assign cfg_if.ready = rst_n;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      // unknown indexes are ignored
      unique case (cfg_if.idx)
        REG_DEBOUNCE_TICKS: cfg_nxt.ticks = cfg_if.data;
        REG_TIME_STEP:      cfg_nxt.step  = cfg_if.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{ticks: TICKS_RST, step: STEP_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // handshake
  assign s1_adv       = !out_vld_r || out_if.ready;
  assign in_if.ready  = rst_n && (!s1_vld_r || s1_adv);
  assign in_acc       = in_if.valid && in_if.ready;

  assign rd_idx = IDX_W'(in_if.channel);
  assign wr_idx = IDX_W'(s1_smp_r.channel);
  assign wr_go  = s1_vld_r && s1_adv && upd_wr;
  assign fwd    = wr_go && (wr_idx == rd_idx);
  assign cur    = rd_vld_r ? rd_r : '0;

  mdet_update u_mdet_update (
    .smp_i   (s1_smp_r),
    .cur_i   (cur),
    .cfg_i   (cfg_r),
    .nxt_o   (upd_nxt),
    .wr_en_o (upd_wr),
    .res_o   (upd_res)
  );

  // state memory
  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem_r[wr_idx] <= upd_nxt;
    end
    if (in_acc) begin
      rd_r <= fwd ? upd_nxt : mem_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_go) begin
        ent_vld_r[wr_idx] <= 1'b1;
      end
      if (in_acc) begin
        rd_vld_r <= fwd || ent_vld_r[rd_idx];
      end
    end
  end

  // update stage and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_smp_r <= '{channel: in_if.channel, pin_level: in_if.pin_level, now_ms: in_if.now_ms};
    end
    if (s1_adv && s1_vld_r) begin
      out_res_r <= upd_res;
    end
  end

  assign out_if.valid           = out_vld_r;
  assign out_if.channel_out     = out_res_r.channel_out;
  assign out_if.stable_level    = out_res_r.stable_level;
  assign out_if.edge_res        = out_res_r.edge_res;
  assign out_if.active_time_ms  = out_res_r.active_time_ms;
  assign out_if.trigger_time_ms = out_res_r.trigger_time_ms;

endmodule

[src/mdet_checker.sv]
module mdet_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [mdet_pkg::CH_W-1:0] channel_out,
  input logic                  stable_level,
  input logic [1:0]            edge_res
);
  import mdet_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(channel_out) && $stable(edge_res)
      && $stable(stable_level))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // rise reports high level, fall reports low level, no other code
  a_edge_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && edge_res != EDGE_NONE |->
      (edge_res == EDGE_RISE && stable_level) || (edge_res == EDGE_FALL && !stable_level))
    else $error("edge code disagrees with level");

  // a fresh result comes from an earlier input transfer
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching input transfer");

endmodule

bind multichannel_debounce_edge_timer mdet_checker u_mdet_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .channel_out  (out_if.channel_out),
  .stable_level (out_if.stable_level),
  .edge_res     (out_if.edge_res)
);
